// File: rtl/c3z_pkg.sv
// Shared types and constants of the 3x3 zero-padded convolution core.
package c3z_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  localparam int PIX_W    = 8;
  localparam int COEF_W   = 16;
  localparam int KROW_W   = 48;
  localparam int PROD_W   = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int TOTAL_W  = ROWSUM_W + 2;
  localparam int RES_W    = 28;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACTION_PIXEL = 1'b0,
    ACTION_DRAIN = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] filtered;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [KROW_W-1:0]    data;
  } cfg_write_t;

  // One classified beat handed from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_zero;
    logic             emit;
    logic             last;
  } cmd_t;

endpackage

// File: rtl/c3z_front.sv
// Front end: raster position tracking, frame restart and classification of each beat.
module c3z_front (
  input  logic                 clk,
  input  logic                 rst,
  input  c3z_pkg::cfg_write_t  cfg,
  input  logic                 accept,
  input  c3z_pkg::pixel_item_t item,
  output logic                 cmd_push,
  output c3z_pkg::cmd_t        cmd
);
  import c3z_pkg::*;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [HEIGHT_W-1:0] in_row, out_row;
  logic [COL_W-1:0]    in_col, out_col;

  logic [HEIGHT_W-1:0] in_row_next, out_row_next;
  logic [COL_W-1:0]    in_col_next, out_col_next;

  logic [WIDTH_W-1:0]  width_req, width_set;
  logic [HEIGHT_W-1:0] height_req, height_set;

  logic                is_drain, frame_done, ignore, restart;
  logic [HEIGHT_W-1:0] row_e, orow_e;
  logic [COL_W-1:0]    col_e, ocol_e;
  logic                col_wrap, ocol_wrap, emit, last;

  // Clamp the requested frame size.
  always_comb begin
    width_req  = cfg.data[WIDTH_W-1:0];
    height_req = cfg.data[HEIGHT_W-1:0];
    if (width_req == '0) begin
      width_set = WIDTH_W'(1);
    end else if (width_req > WIDTH_W'(MAX_WIDTH)) begin
      width_set = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_set = width_req;
    end
    if (height_req == '0) begin
      height_set = HEIGHT_W'(1);
    end else if (height_req > HEIGHT_W'(HEIGHT_LIMIT)) begin
      height_set = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      height_set = height_req;
    end
  end

  always_comb begin
    is_drain   = (item.action == ACTION_DRAIN);
    frame_done = (in_row >= height_eff);
    ignore     = is_drain && !frame_done;
    restart    = !is_drain && frame_done;

    row_e  = restart ? '0 : in_row;
    col_e  = restart ? '0 : in_col;
    orow_e = restart ? '0 : out_row;
    ocol_e = restart ? '0 : out_col;

    col_wrap  = (({1'b0, col_e} + WIDTH_W'(1)) == width_eff);
    ocol_wrap = (({1'b0, ocol_e} + WIDTH_W'(1)) == width_eff);

    emit = ((row_e >= HEIGHT_W'(2)) || ((row_e != '0) && (col_e != '0)))
           && (orow_e < height_eff);
    last = emit && (orow_e == (height_eff - HEIGHT_W'(1))) && ocol_wrap;

    cmd_push     = accept && !ignore;
    cmd.pix      = is_drain ? '0 : item.pixel;
    cmd.col      = col_e;
    cmd.row_ge1  = (row_e != '0);
    cmd.row_ge2  = (row_e >= HEIGHT_W'(2));
    cmd.col_zero = (col_e == '0);
    cmd.emit     = emit;
    cmd.last     = last;

    in_col_next = col_wrap ? '0 : col_e + COL_W'(1);
    in_row_next = col_wrap ? row_e + HEIGHT_W'(1) : row_e;
    if (emit) begin
      out_col_next = ocol_wrap ? '0 : ocol_e + COL_W'(1);
      out_row_next = ocol_wrap ? orow_e + HEIGHT_W'(1) : orow_e;
    end else begin
      out_col_next = ocol_e;
      out_row_next = orow_e;
    end
    // Final result of the frame: start over.
    if (last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_W'(WIDTH_RESET);
      height_eff <= HEIGHT_W'(HEIGHT_RESET);
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else if (cfg.valid && (cfg.index == CFG_IMAGE_WIDTH)) begin
      width_eff <= width_set;
      in_row    <= '0;
      in_col    <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (cfg.valid && (cfg.index == CFG_IMAGE_HEIGHT)) begin
      height_eff <= height_set;
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else if (cmd_push) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    cmd_push && cmd.last |=> (in_row == '0) && (in_col == '0)
                             && (out_row == '0) && (out_col == '0))
    else $error("frame counters not restarted after final result");
`endif

endmodule

// File: rtl/c3z_cmd_queue.sv
// Short command queue between the front end and the back end.
module c3z_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  c3z_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output c3z_pkg::cmd_t head
);
  import c3z_pkg::*;

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign full  = (count == CMD_CNT_W'(CMD_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CMD_CNT_W'(1);
        2'b01:   count <= count - CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/c3z_out_queue.sv
// Result queue that feeds the output side.
module c3z_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  c3z_pkg::result_t push_item,
  input  logic             pop,
  output logic             empty,
  output c3z_pkg::result_t head
);
  import c3z_pkg::*;

  result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0] count;

  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + OUT_CNT_W'(1);
        2'b01:   count <= count - OUT_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/c3z_back.sv
// Back end: line stores, 3x3 window, kernel products and sum pipeline.
module c3z_back (
  input  logic                clk,
  input  logic                rst,
  input  c3z_pkg::cfg_write_t cfg,
  input  logic                cmd_empty,
  input  c3z_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                res_pop,
  output logic                res_push,
  output c3z_pkg::result_t    res
);
  import c3z_pkg::*;

  localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

  logic [KROW_W-1:0]   kernel [3];
  logic [CREDIT_W-1:0] reserved, reserved_next;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_q, lower_q;

  logic             a_valid;
  cmd_t             a_cmd;
  logic             fwd;
  logic [PIX_W-1:0] fwd_upper, fwd_lower;

  logic [PIX_W-1:0]        top_px, mid_px;
  logic [PIX_W-1:0]        new_col [3];
  logic [PIX_W-1:0]        sum_win [3][3];
  logic [PIX_W-1:0]        win [3][3];
  logic signed [COEF_W-1:0] coef [3][3];

  logic                      b_emit, b_last;
  logic signed [PROD_W-1:0]  prod [3][3];
  logic                      c_emit, c_last;
  logic signed [ROWSUM_W-1:0] row_sum [3];
  logic signed [TOTAL_W-1:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel[0] <= '0;
      kernel[1] <= '0;
      kernel[2] <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KERNEL_TOP:    kernel[0] <= cfg.data;
        CFG_KERNEL_MIDDLE: kernel[1] <= cfg.data;
        CFG_KERNEL_BOTTOM: kernel[2] <= cfg.data;
        default:           kernel[0] <= kernel[0];
      endcase
    end
  end

  // Take a command only with a result slot reserved for it.
  assign cmd_pop = !cmd_empty && (reserved < CREDIT_W'(OUT_DEPTH));

  always_comb begin
    reserved_next = reserved + CREDIT_W'(cmd_pop && cmd.emit) - CREDIT_W'(res_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved_next;
    end
  end

  // Line stores: read on pop, write back in the cycle after.
  always_ff @(posedge clk) begin
    if (a_valid) begin
      upper_mem[a_cmd.col] <= mid_px;
      lower_mem[a_cmd.col] <= a_cmd.pix;
    end
    if (cmd_pop) begin
      upper_q <= upper_mem[cmd.col];
      lower_q <= lower_mem[cmd.col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= cmd_pop;
    end
  end

  // Bypass the write that lands on the same edge as the read.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd     <= cmd;
      fwd       <= a_valid && (a_cmd.col == cmd.col);
      fwd_upper <= mid_px;
      fwd_lower <= a_cmd.pix;
    end
  end

  always_comb begin
    top_px = a_cmd.row_ge2 ? (fwd ? fwd_upper : upper_q) : '0;
    mid_px = a_cmd.row_ge1 ? (fwd ? fwd_lower : lower_q) : '0;
    new_col[0] = top_px;
    new_col[1] = mid_px;
    new_col[2] = a_cmd.pix;
    for (int r = 0; r < 3; r++) begin
      sum_win[r][0] = win[r][1];
      sum_win[r][1] = win[r][2];
      sum_win[r][2] = a_cmd.col_zero ? '0 : new_col[r];
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = $signed(kernel[r][COEF_W*c +: COEF_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= a_cmd.col_zero ? '0 : win[r][1];
        win[r][1] <= a_cmd.col_zero ? '0 : win[r][2];
        win[r][2] <= new_col[r];
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed({1'b0, sum_win[r][c]}) * coef[r][c];
        end
      end
      b_last <= a_cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_emit <= 1'b0;
      c_emit <= 1'b0;
    end else begin
      b_emit <= a_valid && a_cmd.emit;
      c_emit <= b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= ROWSUM_W'(prod[r][0]) + ROWSUM_W'(prod[r][1])
                      + ROWSUM_W'(prod[r][2]);
      end
      c_last <= b_last;
    end
  end

  always_comb begin
    total = TOTAL_W'(row_sum[0]) + TOTAL_W'(row_sum[1]) + TOTAL_W'(row_sum[2]);
    res_push     = c_emit;
    res.filtered = total[RES_W-1:0];
    res.last     = c_last;
  end

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= CREDIT_W'(OUT_DEPTH))
    else $error("result credits exceed queue depth");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (reserved != '0))
    else $error("result pushed without a reserved slot");

  a_pop_has_credit: assert property (@(posedge clk) disable iff (rst)
    res_pop |-> (reserved != '0))
    else $error("result popped with no slot reserved");
`endif

endmodule

// File: rtl/conv3x3_zero_padded_core.sv
// Top level of the streaming 3x3 zero-padded convolution core.
// Pixels enter in raster order, one beat per clock while full is low, through push/full; a
// drain beat (action = 1) stands for one padding step after the last pixel. The result for
// a pixel appears once W + 1 further beats have entered (W = effective width), so
// W + 1 drain beats after the final pixel flush the frame; the final result carries
// last. Sustained rate is one beat per clock on both sides while neither side stalls: the
// front end classifies each beat in its accept cycle, a 4-deep command queue decouples it
// from the back end, and the back end reads both 1024 x 8 line stores on one port in the
// cycle it takes a command and writes them back the next, forwarding for one-pixel rows.
// A result passes the line-store read, product and row-sum registers on its way to the
// 8-deep result queue; the back end takes a command only while a result slot is free to
// reserve for it, so full rises when the output side stalls long enough to fill both
// queues. Drain beats before the frame is complete are taken and dropped; a pixel after
// the frame is complete drops the pending results and opens a new frame. The line stores
// need no clearing after reset: rows above the frame read as zero. cfg_ready is always
// high; write registers only while the block is idle. A width or height write restarts
// the frame; kernel writes apply to the next result.
module conv3x3_zero_padded_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  c3z_pkg::pixel_item_t            pixel_item,
  output logic                            empty,
  input  logic                            pop,
  output c3z_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [c3z_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c3z_pkg::KROW_W-1:0]      cfg_data
);
  import c3z_pkg::*;

  cfg_write_t cfg;
  logic       accept;
  logic       cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t       cmd_in, cmd_head;
  logic       res_push, res_pop;
  result_t    res_in;

  // Registers are plain flops; a write is always taken.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Accept a beat whenever the command queue has room.
  assign full    = cmd_full;
  assign accept  = push && !cmd_full;
  assign res_pop = pop && !empty;

  c3z_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (pixel_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  c3z_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .full     (cmd_full),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  c3z_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_pop   (res_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  c3z_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_item (res_in),
    .pop       (res_pop),
    .empty     (empty),
    .head      (result)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the streaming 3x3 zero-padded convolution core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c3z_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 24;   // covers command queue plus back-end stages
  localparam int HOLD_CYCLES   = 300;  // long sink stall that backs up both queues
  localparam int QUIET_LIMIT   = 4000; // cycles without any beat before giving up
  localparam int RANDOM_BEATS  = 750;

  // Pacing of the two sides.
  localparam int PACE_SLOW_SINK   = 0;
  localparam int PACE_SLOW_SOURCE = 1;
  localparam int PACE_FULL        = 2;

  // Shapes of a stimulus frame.
  localparam int FRAME_CLEAN = 0;  // all pixels, then exactly W + 1 drain beats
  localparam int FRAME_NOISY = 1;  // stray drain beats before completion, one more after the final result
  localparam int FRAME_CUT   = 2;  // too few drain beats; next pixel drops the tail
  localparam int FRAME_RAW   = 3;  // random mix of pixel and drain beats

  // Scoreboard: tracks the filter state and holds the sums still owed by the block.
  class conv_scoreboard;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [KROW_W-1:0]   krow [3];
    logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]    lower_line [MAX_WIDTH];
    logic [PIX_W-1:0]    win [9];
    int unsigned         in_row, in_col, out_row, out_col;
    result_t             expected_sums [$];
    int                  errors;

    function new();
      width_reg  = WIDTH_W'(WIDTH_RESET);
      height_reg = HEIGHT_W'(HEIGHT_RESET);
      foreach (krow[i]) krow[i] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    // Weighted sum of the window; shifted uses columns 1,2 as left,centre, right is zero.
    function longint tap_sum(bit shifted);
      longint acc;
      int src;
      logic [COEF_W-1:0] cw;
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          src = c + shifted;
          if (src < 3) begin
            cw = krow[r][COEF_W*c +: COEF_W];
            acc += longint'(win[r*3 + src]) * longint'($signed(cw));
          end
        end
      end
      return acc;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [KROW_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          restart();
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          restart();
        end
        CFG_KERNEL_TOP:    krow[0] = data;
        CFG_KERNEL_MIDDLE: krow[1] = data;
        CFG_KERNEL_BOTTOM: krow[2] = data;
        default: ;
      endcase
    endfunction

    function void note_pixel_beat(pixel_item_t beat);
      int unsigned w, h, total, idx, oidx, ic;
      logic [PIX_W-1:0] p, top, mid;
      bit emit;
      longint acc;
      result_t exp;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
      total = w * h;
      p = beat.pixel;
      acc = 0;
      if (beat.action == ACTION_PIXEL) begin
        // a pixel past the frame end opens a new frame
        if (in_row >= h) restart();
      end else begin
        // drain beats only count once the frame's pixels are all in
        if (in_row < h) return;
        p = '0;
      end

      idx  = in_row * w + in_col;
      oidx = out_row * w + out_col;
      emit = (idx >= w + 1) && (oidx < total);

      ic  = (in_col < MAX_WIDTH) ? in_col : 0;
      top = (in_row >= 2) ? upper_line[ic] : '0;
      mid = (in_row >= 1) ? lower_line[ic] : '0;
      upper_line[ic] = mid;
      lower_line[ic] = p;

      if (in_col == 0) begin
        // row wrap: finish the previous row's last pixel, then clear the window
        if (emit) acc = tap_sum(1'b1);
        foreach (win[i]) win[i] = '0;
      end else begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]     = win[r*3 + 1];
          win[r*3 + 1] = win[r*3 + 2];
        end
      end
      win[2] = top;
      win[5] = mid;
      win[8] = p;
      if (emit && in_col != 0) acc = tap_sum(1'b0);

      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end

      if (!emit) return;

      exp.filtered = acc[RES_W-1:0];
      exp.last     = (oidx == total - 1);
      expected_sums.push_back(exp);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (exp.last) restart();
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d last=%0b, none expected",
                 $time, got.filtered, got.last);
        errors++;
        return;
      end
      exp = expected_sums.pop_front();
      if (got.filtered !== exp.filtered || got.last !== exp.last) begin
        $display("%0t: result mismatch: expected filtered=%0d last=%0b, got filtered=%0d last=%0b",
                 $time, exp.filtered, exp.last, got.filtered, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  pixel_item_t pixel_item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KROW_W-1:0] cfg_data = '0;

  conv_scoreboard model;
  int  pace = PACE_SLOW_SINK;  // written only right after a rising edge
  bit  hold_request = 1'b0;    // main raises it after a rising edge, sink clears it
  int  frame_w, frame_h;       // effective geometry of the current setting
  int  random_beats = 0;

  always #1 clk = ~clk;

  conv3x3_zero_padded_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_item (pixel_item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] k;
    k = KROW_W'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: k = {3{16'h8000}};
      1: k = {3{16'h7FFF}};
      2: for (int c = 0; c < 3; c++)
           k[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 1023)) - 16'd512;
      default: ;
    endcase
    return k;
  endfunction

  // Offer one beat; drop push on idle cycles and hold it while full is high.
  task automatic send_beat(input action_e act, input logic [PIX_W-1:0] pix);
    pixel_item_t beat;
    bit sent;
    beat = '{action: act, pixel: pix};
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk);
      if ((pace == PACE_SLOW_SINK && $urandom_range(0, 99) < 8) ||
          (pace == PACE_SLOW_SOURCE && $urandom_range(0, 99) < 86)) begin
        push <= 1'b0;
      end else begin
        push       <= 1'b1;
        pixel_item <= beat;
        @(posedge clk);
        while (full) @(posedge clk);
        model.note_pixel_beat(beat);
        sent = 1'b1;
      end
    end
  endtask

  // Stop offering, wait for every owed result, then let the pipeline run dry.
  task automatic settle_block();
    @(negedge clk);
    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [KROW_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int w_reg, input int h_reg);
    write_reg(CFG_IMAGE_WIDTH, KROW_W'(w_reg));
    write_reg(CFG_IMAGE_HEIGHT, KROW_W'(h_reg));
    frame_w = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    frame_h = (h_reg == 0) ? 1 : ((h_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_reg);
  endtask

  task automatic send_frame(input int kind);
    int n_pix, n_drain;
    n_pix = frame_w * frame_h;
    if (kind == FRAME_RAW) begin
      // any order at all: drains before the end vanish, pixels after it restart
      repeat (n_pix + frame_w + 1) begin
        if ($urandom_range(0, 2) == 0) send_beat(ACTION_DRAIN, PIX_W'($urandom));
        else send_beat(ACTION_PIXEL, rand_pixel());
        random_beats++;
      end
      return;
    end
    for (int i = 0; i < n_pix; i++) begin
      if (kind == FRAME_NOISY && $urandom_range(0, 9) == 0)
        send_beat(ACTION_DRAIN, PIX_W'($urandom));
      send_beat(ACTION_PIXEL, rand_pixel());
      random_beats++;
    end
    n_drain = (kind == FRAME_CUT) ? $urandom_range(0, frame_w) : frame_w + 1;
    repeat (n_drain) begin
      send_beat(ACTION_DRAIN, PIX_W'($urandom));
      random_beats++;
    end
    // a drain after the final result belongs to no frame and must vanish
    if (kind == FRAME_NOISY) send_beat(ACTION_DRAIN, PIX_W'($urandom));
  endtask

  // Sink: pop at random per pace, or hold off for a long stretch on request.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    do @(posedge clk); while (rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if ((pace == PACE_SLOW_SINK && $urandom_range(0, 99) < 86) ||
                   (pace == PACE_SLOW_SOURCE && $urandom_range(0, 99) < 8)) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) model.check_result(result);
    end
  end

  // Watchdog: give up once no beat of any kind has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int sel, w_reg, h_reg, kind_sel;
    model = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: 1x1 frame from zero registers, extreme coefficients.
    set_geometry(0, 0);
    write_reg(CFG_KERNEL_TOP,    48'h7FFF_8000_7FFF);
    write_reg(CFG_KERNEL_MIDDLE, 48'h8000_7FFF_8000);
    write_reg(CFG_KERNEL_BOTTOM, 48'h7FFF_7FFF_7FFF);
    send_beat(ACTION_DRAIN, 8'hA5);  // early drain: dropped
    send_beat(ACTION_PIXEL, 8'hFF);
    send_beat(ACTION_DRAIN, 8'h5A);
    send_beat(ACTION_DRAIN, 8'hFF);  // flushes the only result, marked last
    send_beat(ACTION_DRAIN, 8'h00);  // after the frame: dropped
    settle_block();

    // Directed: 3x3 of full-scale pixels against the most negative kernel.
    write_reg(CFG_KERNEL_TOP,    {3{16'h8000}});
    write_reg(CFG_KERNEL_MIDDLE, {3{16'h8000}});
    write_reg(CFG_KERNEL_BOTTOM, {3{16'h8000}});
    set_geometry(3, 3);
    repeat (9) send_beat(ACTION_PIXEL, 8'hFF);
    repeat (4) send_beat(ACTION_DRAIN, 8'h00);
    settle_block();

    // Directed: pixel arriving mid-flush drops the pending tail and restarts.
    write_reg(CFG_KERNEL_MIDDLE, {16'h0100, 16'hFF00, 16'h0001});
    set_geometry(2, 2);
    send_beat(ACTION_PIXEL, 8'h00);
    send_beat(ACTION_PIXEL, 8'hFF);
    send_beat(ACTION_PIXEL, 8'h00);
    send_beat(ACTION_PIXEL, 8'hFF);
    send_beat(ACTION_DRAIN, 8'h33);
    send_beat(ACTION_PIXEL, 8'h80);

    // Random phases: pace moves from slow sink to slow source to full speed.
    while (random_beats < RANDOM_BEATS) begin
      settle_block();
      if (random_beats < RANDOM_BEATS / 3) pace = PACE_SLOW_SINK;
      else if (random_beats < 2 * RANDOM_BEATS / 3) pace = PACE_SLOW_SOURCE;
      else pace = PACE_FULL;
      if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) w_reg = 0;
        else if (sel == 1) w_reg = $urandom_range(13, 64);
        else w_reg = $urandom_range(1, 12);
        if (w_reg > 12) h_reg = $urandom_range(0, 3);
        else if ($urandom_range(0, 7) == 0) h_reg = 0;
        else h_reg = $urandom_range(1, 12);
        set_geometry(w_reg, h_reg);
      end
      for (int r = 0; r < 3; r++)
        if ($urandom_range(0, 1) != 0) write_reg(cfg_reg_e'(CFG_KERNEL_TOP + r), rand_krow());
      repeat ($urandom_range(1, 3)) begin
        kind_sel = $urandom_range(0, 9);
        if (kind_sel < 7) send_frame(FRAME_CLEAN);
        else if (kind_sel == 7) send_frame(FRAME_NOISY);
        else if (kind_sel == 8) send_frame(FRAME_CUT);
        else send_frame(FRAME_RAW);
      end
    end

    // Back-pressure: stall the sink long enough that full rises while beats keep coming.
    settle_block();
    pace = PACE_FULL;
    write_reg(CFG_KERNEL_TOP, rand_krow());
    set_geometry(8, 8);
    @(posedge clk);
    hold_request = 1'b1;
    send_frame(FRAME_CLEAN);

    // Widest row, clamped from the largest register value: the start of a row owes nothing.
    settle_block();
    write_reg(CFG_KERNEL_BOTTOM, rand_krow());
    set_geometry(2047, 3);
    repeat (48) send_beat(ACTION_PIXEL, rand_pixel());

    // Tallest frame, clamped from the largest register value, one pixel wide, cut short.
    settle_block();
    set_geometry(1, 8191);
    repeat (40) send_beat(ACTION_PIXEL, rand_pixel());
    send_beat(ACTION_DRAIN, 8'h00);  // frame not complete: dropped

    settle_block();
    if (model.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
